FILE: rtl/mf3x3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3x3_pkg
// Shared types, sizes and the nine-input median network for the 3x3 filter.
// ----------------------------------------------------------------------------
package mf3x3_pkg;

  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 4096;
  localparam int PixW      = 8;
  localparam int WinSize   = 9;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int WCntW     = $clog2(MaxWidth + 1);
  localparam int HCntW     = $clog2(MaxHeight + 1);
  localparam int CfgDataW  = 13;
  localparam int WinIdxW   = $clog2(WinSize);

  typedef logic [PixW-1:0] pix_t;
  typedef logic [WinSize-1:0][PixW-1:0] win_t;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic            rd_en;
    logic [ColW-1:0] addr;
    pix_t            pix;
    logic            up_we;
    logic [ColW-1:0] up_addr;
  } lb_req_t;

  typedef struct packed {
    pix_t up;
    pix_t mid;
  } lb_data_t;

  function automatic win_t cx(input win_t v, input logic [WinIdxW-1:0] a,
                              input logic [WinIdxW-1:0] b);
    win_t r;
    r = v;
    if (v[a] > v[b]) begin
      r[a] = v[b];
      r[b] = v[a];
    end
    return r;
  endfunction

  function automatic pix_t median9(input win_t w);
    win_t p;
    p = w;
    p = cx(p, 4'd1, 4'd2); p = cx(p, 4'd4, 4'd5); p = cx(p, 4'd7, 4'd8);
    p = cx(p, 4'd0, 4'd1); p = cx(p, 4'd3, 4'd4); p = cx(p, 4'd6, 4'd7);
    p = cx(p, 4'd1, 4'd2); p = cx(p, 4'd4, 4'd5); p = cx(p, 4'd7, 4'd8);
    p = cx(p, 4'd0, 4'd3); p = cx(p, 4'd5, 4'd8); p = cx(p, 4'd4, 4'd7);
    p = cx(p, 4'd3, 4'd6); p = cx(p, 4'd1, 4'd4); p = cx(p, 4'd2, 4'd5);
    p = cx(p, 4'd4, 4'd7); p = cx(p, 4'd4, 4'd2); p = cx(p, 4'd6, 4'd4);
    p = cx(p, 4'd4, 4'd2);
    return p[4];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mf3x3_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3x3_line_buf
// Two row memories: read both at the column, push the new pixel into the
// middle row, and as the word moves on, put the old middle value in the upper row.
// ----------------------------------------------------------------------------
module mf3x3_line_buf (
  input  wire                 clk,
  input  mf3x3_pkg::lb_req_t  req,
  output mf3x3_pkg::lb_data_t q
);
  import mf3x3_pkg::*;

  pix_t up_mem  [MaxWidth];
  pix_t mid_mem [MaxWidth];
  pix_t up_q_r;
  pix_t mid_q_r;

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mid_mem[req.addr] <= req.pix;
      mid_q_r           <= mid_mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.up_we) begin
      up_mem[req.up_addr] <= mid_q_r;
    end
    if (req.rd_en) begin
      up_q_r <= up_mem[req.addr];
    end
  end

  assign q.up  = up_q_r;
  assign q.mid = mid_q_r;

endmodule
`default_nettype wire

FILE: rtl/median_filter_3x3.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3
// Raster-order 3x3 median filter with two row memories and a 3x3 window.
//
//   channel | dir | handshake          | word
//   in      | in  | in_valid/in_ready  | in_command, in_pixel_in
//   out     | out | out_valid/out_ready| out_pixel_out, out_frame_last
//   cfg     | in  | cfg_wr_en          | cfg_index, cfg_data
//
// One word per clock sustained while out is not stalled; a result passes the
// row memory read, window shift and median register before it shows at out.
// Synchronous active-low reset clears control, counters and sizes (512x512).
// A stalled out side fills the two inner stages before in_ready drops.
// ----------------------------------------------------------------------------
module median_filter_3x3 (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            in_command,
  input  wire  [7:0]                     in_pixel_in,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [7:0]                     out_pixel_out,
  output logic                           out_frame_last,
  input  wire                            cfg_wr_en,
  input  mf3x3_pkg::cfg_idx_t            cfg_index,
  input  wire  [mf3x3_pkg::CfgDataW-1:0] cfg_data
);
  import mf3x3_pkg::*;

  logic [WCntW-1:0] w_eff_r;
  logic [HCntW-1:0] h_eff_r;
  logic [ColW-1:0]  col_r;
  logic [RowW-1:0]  row_r;
  logic [WCntW-1:0] drain_r;

  logic             s1_vld_r, s1_drain_r, s1_emit_r, s1_keep_r, s1_last_r;
  pix_t             s1_pix_r;
  logic [ColW-1:0]  s1_col_r;
  logic             s2_vld_r, s2_keep_r, s2_last_r;
  win_t             win_r;
  logic             out_valid_r, out_last_r;
  pix_t             out_pixel_r;

  logic             out_adv, s2_free, s1_mv, in_acc;
  logic [ColW-1:0]  col_cur, col_nxt;
  logic [RowW-1:0]  row_cur, row_nxt;
  logic [WCntW-1:0] col_inc;
  logic [HCntW-1:0] row_inc;
  logic             emit, keep, drain_last;
  logic [WCntW-1:0] cfg_w, w_eff_nxt;
  logic [HCntW-1:0] cfg_h, h_eff_nxt;
  lb_req_t          lb_req;
  lb_data_t         lb_q;

  assign out_adv  = !out_valid_r || out_ready;
  assign s2_free  = !s2_vld_r || out_adv;
  assign s1_mv    = s1_vld_r && s2_free;
  assign in_ready = !s1_vld_r || s2_free;
  assign in_acc   = in_valid && in_ready;

  // frame size registers
  always_comb begin
    cfg_w = cfg_data[WCntW-1:0];
    cfg_h = cfg_data[HCntW-1:0];
    w_eff_nxt = w_eff_r;
    h_eff_nxt = h_eff_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          if (cfg_w == '0) w_eff_nxt = WCntW'(1);
          else if (cfg_w > WCntW'(MaxWidth)) w_eff_nxt = WCntW'(MaxWidth);
          else w_eff_nxt = cfg_w;
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg_h == '0) h_eff_nxt = HCntW'(1);
          else if (cfg_h > HCntW'(MaxHeight)) h_eff_nxt = HCntW'(MaxHeight);
          else h_eff_nxt = cfg_h;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= WCntW'(MaxWidth);
      h_eff_r <= HCntW'(512);
    end else begin
      w_eff_r <= w_eff_nxt;
      h_eff_r <= h_eff_nxt;
    end
  end

  // position of the incoming pixel and where it leaves the counters
  always_comb begin
    col_cur = ({1'b0, col_r} >= w_eff_r) ? '0 : col_r;
    row_cur = ({1'b0, row_r} >= h_eff_r) ? '0 : row_r;
    col_inc = {1'b0, col_cur} + WCntW'(1);
    row_inc = {1'b0, row_cur} + HCntW'(1);
    col_nxt = col_inc[ColW-1:0];
    row_nxt = row_cur;
    if (col_inc >= w_eff_r) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff_r) ? '0 : row_inc[RowW-1:0];
    end
    emit       = (row_cur >= RowW'(2)) || ((row_cur == RowW'(1)) && (col_cur != '0));
    keep       = (row_cur >= RowW'(2)) && (col_cur >= ColW'(2));
    drain_last = drain_r >= w_eff_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
    end else if (in_acc) begin
      if (in_command) begin
        drain_r <= drain_last ? '0 : drain_r + WCntW'(1);
      end else begin
        drain_r <= '0;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
      end
    end
  end

  always_comb begin
    lb_req.rd_en   = in_acc && !in_command;
    lb_req.addr    = col_cur;
    lb_req.pix     = in_pixel_in;
    lb_req.up_we   = s1_mv && !s1_drain_r;
    lb_req.up_addr = s1_col_r;
  end

  mf3x3_line_buf u_line_buf (
    .clk (clk),
    .req (lb_req),
    .q   (lb_q)
  );

  // stage 1: row memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_drain_r <= in_command;
      s1_emit_r  <= in_command || emit;
      s1_keep_r  <= !in_command && keep;
      s1_last_r  <= in_command && drain_last;
      s1_pix_r   <= in_pixel_in;
      s1_col_r   <= col_cur;
    end
  end

  // stage 2: window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_free) begin
      s2_vld_r <= s1_mv && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_mv) begin
      s2_keep_r <= s1_keep_r;
      s2_last_r <= s1_last_r;
      if (!s1_drain_r) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= lb_q.up;
        win_r[3] <= win_r[4];
        win_r[4] <= win_r[5];
        win_r[5] <= lb_q.mid;
        win_r[6] <= win_r[7];
        win_r[7] <= win_r[8];
        win_r[8] <= s1_pix_r;
      end
    end
  end

  // stage 3: median and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_pixel_r <= s2_keep_r ? median9(win_r) : '0;
      out_last_r  <= s2_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pixel_r;
  assign out_frame_last = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/mf3x3_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3x3_checker
// Port-level checks for the 3x3 median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mf3x3_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_pixel_out,
  input wire       out_frame_last
);
  import mf3x3_pkg::*;

  localparam pix_t PixZero = '0;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out)
                                && $stable(out_frame_last))
    else $error("out word changed while stalled");

  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_pixel_out == PixZero)
    else $error("frame end word carries a nonzero pixel");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with an empty result register");

endmodule

bind median_filter_3x3 mf3x3_checker u_mf3x3_checker (.*);
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 median filter. A queue of pixel and drain
// words feeds a bursty driver. A tracker mirrors the row memories, window and
// counters and queues the expected medians. A monitor compares every result
// word field by field under a stalling receiver. Frame sizes change only
// while the filter is idle, and sweep tiny, clamped and wide frames.
// ----------------------------------------------------------------------------
module testbench;

  import mf3x3_pkg::*;

  localparam int LongHold  = 400;
  localparam int CycleCap  = 400000;
  localparam int SettleCyc = 8;
  localparam int RandWords = 30;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum int {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_EVERY_THIRD
  } rx_mode_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] pix;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       frame_end;
  } filt_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = 1'b0;
  logic [7:0]  in_pixel_in = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_pixel_out;
  logic        out_frame_last;
  logic        cfg_wr_en = 1'b0;
  cfg_idx_t    cfg_index = CFG_FRAME_WIDTH;
  logic [12:0] cfg_data = 13'd0;

  median_filter_3x3 uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pixel_word_t word_q[$];
  filt_out_t   median_q[$];
  int          err_cnt = 0;
  int          words_queued = 0;
  int          cycle_cnt = 0;

  // tracker state
  logic [9:0]  reg_width = 10'd512;
  logic [12:0] reg_height = 13'd512;
  logic [7:0]  row_buf_up [0:511];
  logic [7:0]  row_buf_mid [0:511];
  logic [7:0]  win_px [0:8] = '{default: 8'd0};
  int          cur_col = 0;
  int          cur_row = 0;
  int          drain_seen = 0;

  // sender and receiver pacing
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;

  function automatic int active_width();
    if (reg_width == 10'd0) return 1;
    if (reg_width > 10'd512) return 512;
    return int'(reg_width);
  endfunction

  function automatic int active_height();
    if (reg_height == 13'd0) return 1;
    if (reg_height > 13'd4096) return 4096;
    return int'(reg_height);
  endfunction

  function automatic logic [7:0] middle_of_nine(input logic [8:0][7:0] v);
    logic [7:0] t;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8 - i; j++) begin
        if (v[j] > v[j+1]) begin
          t = v[j];
          v[j] = v[j+1];
          v[j+1] = t;
        end
      end
    end
    return v[4];
  endfunction

  task automatic track_word(input cmd_t cmd, input logic [7:0] pix);
    int w, h, col, row, crow, ccol;
    logic [7:0] up, mid;
    logic [8:0][7:0] pack;
    filt_out_t r;
    w = active_width();
    h = active_height();
    r = '0;
    if (cmd == CMD_DRAIN) begin
      if (drain_seen >= w) begin
        r.frame_end = 1'b1;
        drain_seen = 0;
      end else begin
        drain_seen++;
      end
      median_q.push_back(r);
    end else begin
      drain_seen = 0;
      col = (cur_col >= w) ? 0 : cur_col;
      row = (cur_row >= h) ? 0 : cur_row;
      up = row_buf_up[col];
      mid = row_buf_mid[col];
      win_px[0] = win_px[1]; win_px[1] = win_px[2]; win_px[2] = up;
      win_px[3] = win_px[4]; win_px[4] = win_px[5]; win_px[5] = mid;
      win_px[6] = win_px[7]; win_px[7] = win_px[8]; win_px[8] = pix;
      row_buf_up[col] = mid;
      row_buf_mid[col] = pix;
      if (row >= 2 || (row == 1 && col >= 1)) begin
        if (col >= 1) begin
          crow = row - 1;
          ccol = col - 1;
        end else begin
          crow = row - 2;
          ccol = w - 1;
        end
        if (crow >= 1 && crow + 1 < h && ccol >= 1 && ccol + 1 < w) begin
          for (int i = 0; i < 9; i++) pack[i] = win_px[i];
          r.pix = middle_of_nine(pack);
        end
        median_q.push_back(r);
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
      cur_col = col;
      cur_row = row;
    end
  endtask

  always @(posedge clk) begin : tx_proc
    pixel_word_t wd;
    logic offer;
    offer = 1'b0;
    wd = '0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (word_q.size() > 0) begin
        wd = word_q.pop_front();
        offer = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      in_valid <= offer;
      if (offer) begin
        in_command <= wd.cmd;
        in_pixel_in <= wd.pix;
      end
    end
  end

  always @(posedge clk) begin : rx_proc
    logic rdy;
    rdy = 1'b1;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = LongHold;
      rdy = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   rdy = 1'b1;
        RX_HALF:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
        default:   rdy = (mode_left % 3 == 0);
      endcase
    end
    out_ready <= rdy;
  end

  always @(posedge clk) begin : mon_proc
    filt_out_t e;
    if (rst_n) begin
      if (in_valid && in_ready) track_word(cmd_t'(in_command), in_pixel_in);
      if (out_valid && out_ready) begin
        if (median_q.size() == 0) begin
          $error("unexpected out word: pixel_out %0d frame_last %0b",
                 out_pixel_out, out_frame_last);
          err_cnt++;
        end else begin
          e = median_q.pop_front();
          if (out_pixel_out !== e.pix) begin
            $error("pixel_out: expected %0d, got %0d", e.pix, out_pixel_out);
            err_cnt++;
          end
          if (out_frame_last !== e.frame_end) begin
            $error("frame_last: expected %0b, got %0b", e.frame_end, out_frame_last);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleCap) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_word(input cmd_t cmd, input logic [7:0] pix);
    pixel_word_t wd;
    wd.cmd = cmd;
    wd.pix = pix;
    word_q.push_back(wd);
    words_queued++;
  endtask

  function automatic logic [7:0] next_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic wait_idle();
    while (word_q.size() != 0 || in_valid || median_q.size() != 0) @(negedge clk);
    repeat (SettleCyc) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [12:0] d);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) reg_width = d[9:0];
    else reg_height = d;
    @(negedge clk);
  endtask

  task automatic set_size(input logic [12:0] wd, input logic [12:0] hd);
    write_reg(CFG_FRAME_WIDTH, wd);
    write_reg(CFG_FRAME_HEIGHT, hd);
  endtask

  // one pixel in a 1x1 frame brings the counters back to the origin
  task automatic home_counters();
    set_size(13'd1, 13'd1);
    push_word(CMD_PIXEL, next_pixel());
    wait_idle();
  endtask

  task automatic queue_stream(input int w, input int h, input int npix);
    int pos, nd;
    pos = 0;
    for (int k = 0; k < npix; k++) begin
      if ($urandom_range(0, 99) < 3) begin
        repeat ($urandom_range(1, 3)) push_word(CMD_DRAIN, next_pixel());
      end
      push_word(CMD_PIXEL, next_pixel());
      pos++;
      if (pos == w * h) begin
        pos = 0;
        nd = ($urandom_range(0, 99) < 85) ? w + 1 : $urandom_range(0, 2 * w + 3);
        repeat (nd) push_word(CMD_DRAIN, next_pixel());
      end
    end
  endtask

  task automatic run_phase(input logic [12:0] wd, input logic [12:0] hd, input int frames);
    wait_idle();
    home_counters();
    set_size(wd, hd);
    queue_stream(active_width(), active_height(), frames * active_width() * active_height());
  endtask

  initial begin : stim
    logic [7:0] dir_px [0:15];
    logic [12:0] wd, hd;
    int rand_start;
    dir_px = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd170, 8'd85, 8'd255, 8'd0,
               8'd1, 8'd128, 8'd254, 8'd127, 8'd255, 8'd255, 8'd0, 8'd0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: one 4x4 frame of extreme values and its drain
    set_size(13'd4, 13'd4);
    for (int i = 0; i < 16; i++) push_word(CMD_PIXEL, dir_px[i]);
    repeat (5) push_word(CMD_DRAIN, 8'd255);

    // width write with stray upper bits, minimum interior, tiny frames
    run_phase(13'h1C05, 13'd5, 2);
    run_phase(13'd3, 13'd3, 2);
    run_phase(13'd1, 13'd6, 2);
    run_phase(13'd2, 13'd4, 2);
    run_phase(13'd6, 13'd1, 2);
    run_phase(13'd0, 13'd0, 3);

    // height clamp on a two-pixel-wide stream
    run_phase(13'd2, 13'h1FFF, 0);
    queue_stream(2, 4096, 20);
    repeat (3) push_word(CMD_DRAIN, next_pixel());

    // width clamp: just past the first row of a wide frame
    run_phase(13'd1023, 13'd3, 0);
    queue_stream(512, 3, 514);

    // shrink both sizes below the counters mid-frame
    run_phase(13'd8, 13'd8, 0);
    queue_stream(8, 8, 29);
    wait_idle();
    set_size(13'd4, 13'd3);
    queue_stream(4, 3, 24);

    // long receiver hold while the sender keeps offering
    run_phase(13'd8, 13'd6, 1);
    hold_asked++;

    // sender pauses until the filter has emptied
    run_phase(13'd7, 13'd5, 1);
    wait_idle();
    queue_stream(7, 5, 35);

    rand_start = words_queued;
    while (words_queued - rand_start < RandWords) begin
      if ($urandom_range(0, 9) < 8) begin
        wd = 13'($urandom_range(3, 12));
        hd = 13'($urandom_range(3, 8));
      end else begin
        wd = 13'($urandom_range(0, 2));
        hd = 13'($urandom_range(0, 10));
      end
      run_phase(wd, hd, 1);
      if ($urandom_range(0, 9) == 0) hold_asked++;
    end

    while (word_q.size() != 0 || in_valid || median_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mf3x3_pkg.sv
rtl/mf3x3_line_buf.sv
rtl/median_filter_3x3.sv
rtl/mf3x3_checker.sv
bench/testbench.sv
